FILE: design/polar_to_cartesian_deg_defines.svh
// Assertion macros for the polar to rectangular converter.
`ifndef POLAR_TO_CARTESIAN_DEG_DEFINES_SVH
`define POLAR_TO_CARTESIAN_DEG_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define P2C_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polar_to_cartesian_deg: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polar_to_cartesian_deg: assertion failed");

`else

`define P2C_ASSERT_NOW(label, clk, rst, ante, cons)
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/p2c_pkg.sv
// Shared constants, types and tables of the polar to rectangular converter.
package p2c_pkg;

  localparam int DATA_W         = 32;
  localparam int ROTATION_STEPS = 16;
  localparam int ATAN_LEN       = 30;
  localparam int STEPS          = (ROTATION_STEPS > ATAN_LEN) ? ATAN_LEN : ROTATION_STEPS;

  // Datapath widths: x and y in Q16.24 with headroom for the rotation gain.
  localparam int XY_W    = 42;
  localparam int Z_W     = 25;
  localparam int RM_W    = 25;
  localparam int FRAC_SH = 8;
  localparam int ROUND   = 128;
  localparam int FIN_W   = XY_W - FRAC_SH + 1;

  // Gain multiply: length times K in Q0.32, kept as Q16.24.
  localparam int MUL_W   = 66;
  localparam int GAIN_SH = 24;
  localparam logic [DATA_W-1:0] GAIN_Q32 = 32'd2608131496;

  // Angle reduction: 360 degrees in Q16.16 is 45 * 2^19.
  localparam int LOW_W      = 19;
  localparam int Q_W        = DATA_W - LOW_W;
  localparam int U_W        = 14;
  localparam int MOD_OFS    = 4140;
  localparam int RECIP_K    = 11651;
  localparam int RECIP_SH   = 19;
  localparam int PROD_W     = 28;
  localparam int QUO_W      = 9;
  localparam int REM_W      = RM_W - LOW_W;
  localparam int TURN_UNITS = 45;

  localparam logic [RM_W-1:0] DEG_90  = RM_W'(90 * 65536);
  localparam logic [RM_W-1:0] DEG_180 = RM_W'(180 * 65536);
  localparam logic [RM_W-1:0] DEG_270 = RM_W'(270 * 65536);
  localparam logic [RM_W-1:0] DEG_360 = RM_W'(360 * 65536);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [FIN_W-1:0]  fin_t;

  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_POS90,
    SP_HALF,
    SP_NEG90
  } special_t;

  typedef struct packed {
    data_t    len;
    special_t sp;
    logic     neg;
    logic     fold;
  } ctl_t;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest.
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379, 25'd117304,
    25'd58666,   25'd29335,   25'd14668,  25'd7334,   25'd3667,   25'd1833,
    25'd917,     25'd458,     25'd229,    25'd115,    25'd57,     25'd29,
    25'd14,      25'd7,       25'd4,      25'd2,      25'd1,      25'd0,
    25'd0,       25'd0,       25'd0,      25'd0,      25'd0,      25'd0
  };

endpackage

FILE: design/p2c_if.sv
// Handshake channels for polar items and rectangular result items.
interface p2c_in_if import p2c_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t length_in;
  data_t angle_deg;

  modport source (output valid, output length_in, output angle_deg, input ready);
  modport sink (input valid, input length_in, input angle_deg, output ready);
endinterface

interface p2c_out_if import p2c_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t x_out;
  data_t y_out;

  modport source (output valid, output x_out, output y_out, input ready);
  modport sink (input valid, input x_out, input y_out, output ready);
endinterface

FILE: design/polar_to_cartesian_deg.sv
// Top level of the polar to rectangular converter with angles in degrees.
//
// The polar channel carries one item per handshake: a signed Q16.16 length and
// a signed Q16.16 angle in degrees of any value. The rect channel returns one
// item for each, x = length*cos and y = length*sin in Q16.16, saturated, in the
// order the items arrived. Angles of 0, 90, 180 and -90 degrees after
// reduction give exact axis results.
// A new item is taken every clock cycle unless the receiver stalls and the
// pipeline is full. An accepted item reaches rect through three
// stages of angle reduction and gain multiply, one stage per CORDIC iteration,
// then rounding and saturation into the output register.
// Every stage carries a valid bit and advances when it is empty or the next
// stage moves, so bubbles are squeezed out. When the receiver stalls, the
// result waits in the output register and the pipeline keeps filling; ready on
// polar falls only once every stage holds an item.
// Reset clears all valid bits; the pipeline is empty and ready after it.
`include "polar_to_cartesian_deg_defines.svh"

module polar_to_cartesian_deg import p2c_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  p2c_in_if.sink    polar,
  p2c_out_if.source rect
);

  logic red_valid, cor_ready;
  ctl_t red_ctl;
  xy_t  red_x;
  z_t   red_z;

  logic cor_valid, fin_ready;
  ctl_t cor_ctl;
  xy_t  cor_x, cor_y;

  p2c_reduce u_reduce (
    .clk        (clk),
    .rst        (rst),
    .polar      (polar),
    .sink_ready (cor_ready),
    .valid      (red_valid),
    .ctl        (red_ctl),
    .x          (red_x),
    .z          (red_z)
  );

  p2c_cordic u_cordic (
    .clk        (clk),
    .rst        (rst),
    .valid      (red_valid),
    .ready      (cor_ready),
    .ctl        (red_ctl),
    .x          (red_x),
    .z          (red_z),
    .res_valid  (cor_valid),
    .sink_ready (fin_ready),
    .res_ctl    (cor_ctl),
    .res_x      (cor_x),
    .res_y      (cor_y)
  );

  p2c_finish u_finish (
    .clk   (clk),
    .rst   (rst),
    .valid (cor_valid),
    .ready (fin_ready),
    .ctl   (cor_ctl),
    .x     (cor_x),
    .y     (cor_y),
    .rect  (rect)
  );

  // Input back-pressure can only come from a stalled, full output register.
  `P2C_ASSERT_NOW(a_stall_source, clk, rst, !polar.ready, rect.valid && !rect.ready)

  // A folded angle that is not on an axis lies strictly inside the first quadrant.
  `P2C_ASSERT_NOW(a_fold_range, clk, rst, red_valid && (red_ctl.sp == SP_NONE),
                  !red_z[Z_W-1] && (red_z != '0) && (red_z < z_t'(DEG_90)))

  // An item held at the end of the rotation is kept while the finish stage is full.
  `P2C_ASSERT_NEXT(a_cordic_hold, clk, rst, cor_valid && !fin_ready,
                   cor_valid && $stable(cor_x) && $stable(cor_y))

endmodule

FILE: design/p2c_reduce.sv
// Angle reduction, quadrant fold and gain multiply: three pipeline stages.
module p2c_reduce import p2c_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  p2c_in_if.sink polar,
  input  logic   sink_ready,
  output logic   valid,
  output ctl_t   ctl,
  output xy_t    x,
  output z_t     z
);

  logic en1, en2, en3;
  logic v1, v2, v3;

  // Stage 1 signals
  logic signed [U_W:0]  u_s;
  logic [U_W-1:0]       u_c;
  logic signed [MUL_W-1:0] mul;
  logic [PROD_W-1:0]    uprod_c;

  data_t             len1;
  logic [LOW_W-1:0]  low1;
  logic [U_W-1:0]    u1;
  logic [PROD_W-1:0] uprod1;
  xy_t               x1;

  // Stage 2 signals
  logic [QUO_W-1:0] quo;
  logic [U_W-1:0]   turns;
  logic [U_W-1:0]   rem;

  data_t            len2;
  logic [RM_W-1:0]  rm2;
  xy_t              x2;

  // Stage 3 signals
  logic            neg_c, fold_c;
  logic [RM_W-1:0] mag, fa;
  special_t        sp_c;

  ctl_t ctl3;
  xy_t  x3;
  z_t   z3;

  assign en3 = !v3 || sink_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign polar.ready = en1;

  // The angle splits into a multiple of 2^19 and a low part; the multiple is
  // offset by a whole number of turns so that it stays non-negative.
  assign u_s = {{(U_W + 1 - Q_W){polar.angle_deg[DATA_W-1]}},
                polar.angle_deg[DATA_W-1:LOW_W]} + (U_W + 1)'(MOD_OFS);
  assign u_c = u_s[U_W-1:0];
  assign uprod_c = PROD_W'(u_c) * PROD_W'(RECIP_K);
  assign mul = $signed({{(MUL_W-DATA_W){polar.length_in[DATA_W-1]}}, polar.length_in})
             * $signed({{(MUL_W-DATA_W){1'b0}}, GAIN_Q32});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= polar.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && polar.valid) begin
      len1   <= polar.length_in;
      low1   <= polar.angle_deg[LOW_W-1:0];
      u1     <= u_c;
      uprod1 <= uprod_c;
      x1     <= mul[GAIN_SH +: XY_W];
    end
  end

  // Remainder of the turn count by 45, quotient taken by reciprocal.
  assign quo   = uprod1[RECIP_SH +: QUO_W];
  assign turns = U_W'(quo) * U_W'(TURN_UNITS);
  assign rem   = u1 - turns;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      len2 <= len1;
      rm2  <= {rem[REM_W-1:0], low1};
      x2   <= x1;
    end
  end

  always_comb begin
    neg_c  = rm2 > DEG_180;
    mag    = neg_c ? (DEG_360 - rm2) : rm2;
    fold_c = mag > DEG_90;
    fa     = fold_c ? (DEG_180 - mag) : mag;
    if (rm2 == '0) begin
      sp_c = SP_ZERO;
    end else if (rm2 == DEG_90) begin
      sp_c = SP_POS90;
    end else if (rm2 == DEG_180) begin
      sp_c = SP_HALF;
    end else if (rm2 == DEG_270) begin
      sp_c = SP_NEG90;
    end else begin
      sp_c = SP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ctl3.len  <= len2;
      ctl3.sp   <= sp_c;
      ctl3.neg  <= neg_c;
      ctl3.fold <= fold_c;
      x3        <= x2;
      z3        <= z_t'(fa);
    end
  end

  assign valid = v3;
  assign ctl   = ctl3;
  assign x     = x3;
  assign z     = z3;

endmodule

FILE: design/p2c_cordic.sv
// Unrolled CORDIC rotation, one register stage per iteration.
module p2c_cordic import p2c_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  ctl_t ctl,
  input  xy_t  x,
  input  z_t   z,
  output logic res_valid,
  input  logic sink_ready,
  output ctl_t res_ctl,
  output xy_t  res_x,
  output xy_t  res_y
);

  logic v_q  [STEPS];
  logic en   [STEPS];
  xy_t  x_q  [STEPS];
  xy_t  y_q  [STEPS];
  z_t   z_q  [STEPS];
  ctl_t c_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic vp, nr, rot;
    xy_t  xp, yp, dx, dy;
    z_t   zp;
    ctl_t cp;

    if (k == 0) begin : g_first
      assign vp = valid;
      assign xp = x;
      assign yp = '0;
      assign zp = z;
      assign cp = ctl;
    end else begin : g_rest
      assign vp = v_q[k-1];
      assign xp = x_q[k-1];
      assign yp = y_q[k-1];
      assign zp = z_q[k-1];
      assign cp = c_q[k-1];
    end

    if (k == STEPS - 1) begin : g_last
      assign nr = sink_ready;
    end else begin : g_mid
      assign nr = en[k+1];
    end

    assign en[k] = !v_q[k] || nr;
    assign dx    = yp >>> k;
    assign dy    = xp >>> k;
    // Rotate towards zero residual angle; a residual of zero counts as positive.
    assign rot   = !zp[Z_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && vp) begin
        c_q[k] <= cp;
        if (rot) begin
          x_q[k] <= xp - dx;
          y_q[k] <= yp + dy;
          z_q[k] <= zp - ATAN_TAB[k];
        end else begin
          x_q[k] <= xp + dx;
          y_q[k] <= yp - dy;
          z_q[k] <= zp + ATAN_TAB[k];
        end
      end
    end
  end

  assign ready     = en[0];
  assign res_valid = v_q[STEPS-1];
  assign res_ctl   = c_q[STEPS-1];
  assign res_x     = x_q[STEPS-1];
  assign res_y     = y_q[STEPS-1];

endmodule

FILE: design/p2c_finish.sv
// Rounding, quadrant sign restore, axis cases and saturation into the output register.
module p2c_finish import p2c_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  output logic      ready,
  input  ctl_t      ctl,
  input  xy_t       x,
  input  xy_t       y,
  p2c_out_if.source rect
);

  function automatic data_t sat_fin(input fin_t v);
    logic hi_same;
    hi_same = (v[FIN_W-1:DATA_W-1] == '0) || (v[FIN_W-1:DATA_W-1] == '1);
    if (hi_same) return v[DATA_W-1:0];
    return v[FIN_W-1] ? S_MIN : S_MAX;
  endfunction

  function automatic data_t neg_sat(input data_t v);
    if (v == S_MIN) return S_MAX;
    return -v;
  endfunction

  logic en1, en2;
  logic v1, v2;
  xy_t  xa, ya;
  fin_t xe, ye;
  ctl_t c1;
  fin_t xs1, ys1;
  data_t xo, yo;
  data_t x2, y2;

  assign en2   = !v2 || rect.ready;
  assign en1   = !v1 || en2;
  assign ready = en1;

  // Round Q16.24 to Q16.16 to nearest, ties upwards.
  assign xa = x + xy_t'(ROUND);
  assign ya = y + xy_t'(ROUND);
  assign xe = {xa[XY_W-1], xa[XY_W-1:FRAC_SH]};
  assign ye = {ya[XY_W-1], ya[XY_W-1:FRAC_SH]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && valid) begin
      c1  <= ctl;
      xs1 <= ctl.fold ? -xe : xe;
      ys1 <= ctl.neg ? -ye : ye;
    end
  end

  // Axis angles bypass the rotation result entirely.
  always_comb begin
    case (c1.sp)
      SP_ZERO: begin
        xo = c1.len;
        yo = '0;
      end
      SP_POS90: begin
        xo = '0;
        yo = c1.len;
      end
      SP_HALF: begin
        xo = neg_sat(c1.len);
        yo = '0;
      end
      SP_NEG90: begin
        xo = '0;
        yo = neg_sat(c1.len);
      end
      default: begin
        xo = sat_fin(xs1);
        yo = sat_fin(ys1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      x2 <= xo;
      y2 <= yo;
    end
  end

  assign rect.valid = v2;
  assign rect.x_out = x2;
  assign rect.y_out = y2;

endmodule
